[sv/pdmcic_pkg.sv]
// ---------------------------------------------------------------------------
// pdmcic_pkg: shared types for the PDM CIC decimator
// Sample width, reset value of the filter state and inter-cell link types.
// ---------------------------------------------------------------------------
package pdmcic_pkg;

   localparam int SAMPLE_W = 16;

   typedef logic [SAMPLE_W-1:0] sample_type;

   localparam sample_type STATE_RESET = 16'h8000;
   localparam sample_type STEP_POS    = 16'h0001;   // +1
   localparam sample_type STEP_NEG    = 16'hFFFF;   // -1

   // one PDM bit (or its running sum) moving down the integrator row
   typedef struct packed {
      logic       valid;
      logic       last;    // final bit of its word
      sample_type value;
   } integ_link_type;

   // one word's sample moving down the comb row
   typedef struct packed {
      logic       valid;
      sample_type value;
   } comb_link_type;

endpackage

[sv/pdmcic_integ_cell.sv]
// ---------------------------------------------------------------------------
// pdmcic_integ_cell: one integrator of the CIC row
// Accumulates the value handed over by its neighbor, modulo 2^16, and passes
// its updated sum on in the cycle after, from a register.
// ---------------------------------------------------------------------------
module pdmcic_integ_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  pdmcic_pkg::integ_link_type link_i,
   output pdmcic_pkg::integ_link_type link_o
);
   import pdmcic_pkg::*;

   sample_type sum_ff, sum_in;
   logic       valid_ff, last_ff;

   always_comb begin
      sum_in = sum_ff;
      if (link_i.valid) begin
         sum_in = sum_ff + link_i.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= STATE_RESET;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         valid_ff <= link_i.valid;
         last_ff  <= link_i.valid & link_i.last;
      end
   end

   assign link_o.valid = valid_ff;
   assign link_o.last  = last_ff;
   assign link_o.value = sum_ff;

endmodule

[sv/pdmcic_comb_cell.sv]
// ---------------------------------------------------------------------------
// pdmcic_comb_cell: one comb stage of the CIC row
// Subtracts the previous word's input (delay of one) modulo 2^16.
// ---------------------------------------------------------------------------
module pdmcic_comb_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  pdmcic_pkg::comb_link_type link_i,
   output pdmcic_pkg::comb_link_type link_o
);
   import pdmcic_pkg::*;

   sample_type delay_ff, delay_in;
   sample_type diff_ff, diff_in;
   logic       valid_ff;

   always_comb begin
      delay_in = delay_ff;
      diff_in  = diff_ff;
      if (link_i.valid) begin
         delay_in = link_i.value;
         diff_in  = link_i.value - delay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= STATE_RESET;
         valid_ff <= 1'b0;
      end else begin
         delay_ff <= delay_in;
         valid_ff <= link_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign link_o.valid = valid_ff;
   assign link_o.value = diff_ff;

endmodule

[sv/pdm_cic_decimator_unit.sv]
// ---------------------------------------------------------------------------
// pdm_cic_decimator_unit: PDM to PCM converter, CIC decimator
// Each req_ transaction carries one word of PDM bits; each yields exactly one
// 16-bit PCM sample on the rsp_ channel, in order.
//
// Usage:
//  - Bits are shifted out MSB first, one per cycle, into a row of STAGES
//    integrator cells; each cell updates in the cycle after its neighbor.
//  - After the word's last bit reaches the final integrator, the sum runs
//    through a row of STAGES comb cells, one cell per cycle.
//  - The sample is offered from the output queue, which it enters from the
//    final comb cell.
//  - The bit shifter feeding the integrator row paces the words: a new word
//    is taken in the cycle the last bit of the previous one leaves the
//    shifter, if fewer than two words are outstanding.
//  - Results wait in a two-entry output queue; at most two words are
//    outstanding, so a stalled receiver stops req_ready and nothing is lost.
//  - Reset (synchronous) sets all integrators and comb delays to 0x8000 and
//    empties the shifter and the output queue.
// ---------------------------------------------------------------------------
module pdm_cic_decimator_unit #(
   parameter int STAGES        = 4,
   parameter int BITS_PER_WORD = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [15:0]                        req_pdm_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pdmcic_pkg::SAMPLE_W-1:0] rsp_pcm_sample
);
   import pdmcic_pkg::*;

   localparam int CNT_W = $clog2(BITS_PER_WORD + 1);

   // ---- bit shifter ----
   logic [BITS_PER_WORD-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [1:0]               pend_ff, pend_in;
   logic                     req_fire, rsp_fire, shifter_free;

   assign shifter_free = (cnt_ff == CNT_W'(0)) || (cnt_ff == CNT_W'(1));
   assign req_ready    = shifter_free && (pend_ff != 2'd2);
   assign req_fire     = req_valid && req_ready;
   assign rsp_fire     = rsp_valid && rsp_ready;

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (cnt_ff != CNT_W'(0)) begin
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - CNT_W'(1);
      end
      if (req_fire) begin
         shift_in = BITS_PER_WORD'(req_pdm_word);
         cnt_in   = CNT_W'(BITS_PER_WORD);
      end
      pend_in = pend_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // ---- integrator row ----
   integ_link_type ilink [STAGES+1];

   assign ilink[0].valid = (cnt_ff != CNT_W'(0));
   assign ilink[0].last  = (cnt_ff == CNT_W'(1));
   assign ilink[0].value = shift_ff[BITS_PER_WORD-1] ? STEP_POS : STEP_NEG;

   for (genvar s = 0; s < STAGES; s++) begin : g_integ
      pdmcic_integ_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .link_i (ilink[s]),
         .link_o (ilink[s+1])
      );
   end

   // ---- comb row ----
   comb_link_type clink [STAGES+1];

   assign clink[0].valid = ilink[STAGES].valid & ilink[STAGES].last;
   assign clink[0].value = ilink[STAGES].value;

   for (genvar s = 0; s < STAGES; s++) begin : g_comb
      pdmcic_comb_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .link_i (clink[s]),
         .link_o (clink[s+1])
      );
   end

   // ---- output queue, two entries ----
   sample_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       q_push;

   assign q_push = clink[STAGES].valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_push;
      rd_ptr_in = rd_ptr_ff ^ rsp_fire;
      q_cnt_in  = q_cnt_ff + {1'b0, q_push} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wr_ptr_ff] <= clink[STAGES].value;
      end
   end

   assign rsp_valid      = (q_cnt_ff != 2'd0);
   assign rsp_pcm_sample = $signed(q_ff[rd_ptr_ff]);

endmodule

[dv/pdm_cic_decimator_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pdm_cic_decimator_unit_checker: sample predictor and scoreboard
// Watches the req_/rsp_ channels, runs each accepted PDM word through its own
// four-stage CIC decimator and compares every PCM sample with the oldest
// predicted one, in order.
// ---------------------------------------------------------------------------
module pdm_cic_decimator_unit_checker #(
   parameter int STAGES        = 4,
   parameter int BITS_PER_WORD = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [15:0]                            req_pdm_word,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [pdmcic_pkg::SAMPLE_W-1:0] rsp_pcm_sample,
   output int                                     fail_count,
   output int                                     pending_count
);
   import pdmcic_pkg::*;

   sample_type integ_sum [STAGES];
   sample_type comb_dly [STAGES];
   sample_type pcm_expected [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // one word: every bit through the integrator row, then one pass of the combs
   function automatic sample_type decimate_word(input logic [15:0] word);
      logic [63:0] bits;
      sample_type  v;
      sample_type  d;
      bits = 64'(word);   // bits above the field read as zero, i.e. -1
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         integ_sum[0] = integ_sum[0] + (bits[BITS_PER_WORD-1-i] ? STEP_POS : STEP_NEG);
         for (int s = 1; s < STAGES; s++)
            integ_sum[s] = integ_sum[s] + integ_sum[s-1];
      end
      v = integ_sum[STAGES-1];
      for (int s = 0; s < STAGES; s++) begin
         d = v - comb_dly[s];
         comb_dly[s] = v;
         v = d;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            integ_sum[s] = STATE_RESET;
            comb_dly[s]  = STATE_RESET;
         end
         pcm_expected.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pcm_expected.size() == 0) begin
               $error("pcm_sample: unexpected transaction, expected none, actual %0d",
                      rsp_pcm_sample);
               fail_count = fail_count + 1;
            end else begin
               want = pcm_expected.pop_front();
               if (rsp_pcm_sample !== want) begin
                  $error("pcm_sample mismatch: expected %0d, actual %0d",
                         $signed(want), rsp_pcm_sample);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            pcm_expected.push_back(decimate_word(req_pdm_word));
      end
      pending_count = pcm_expected.size();
   end

endmodule

[dv/pdm_cic_decimator_unit_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pdm_cic_decimator_unit_test: testbench top for the PDM CIC decimator
// Drives directed edge words, then random, sigma-delta shaped and near full scale
// PDM streams with random gaps and receiver stalls; the checker predicts and compares.
// ---------------------------------------------------------------------------
module pdm_cic_decimator_unit_test;
   import pdmcic_pkg::*;

   localparam int RANDOM_WORDS = 1630;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [15:0]                req_pdm_word;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_pcm_sample;
   int                         fail_count;
   int                         pending_count;
   int                         cycle_count;
   int                         words_sent;
   logic [15:0]                sd_acc;

   pdm_cic_decimator_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pdm_word   (req_pdm_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pcm_sample (rsp_pcm_sample)
   );

   pdm_cic_decimator_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pdm_word   (req_pdm_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pcm_sample (rsp_pcm_sample),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pdm_cic_decimator_unit test failed");
         $finish;
      end
   end

   // mostly none, often short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // first-order sigma-delta: density of ones tracks the level
   function automatic logic [15:0] sigma_delta_word(input logic [15:0] level);
      logic [16:0] sum;
      logic [15:0] word;
      for (int b = 15; b >= 0; b--) begin
         sum     = {1'b0, sd_acc} + {1'b0, level};
         word[b] = sum[16];
         sd_acc  = sum[15:0];
      end
      return word;
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input logic [15:0] word, input int gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_pdm_word = word;
      do @(posedge clock); while (!req_ready);
      words_sent = words_sent + 1;
      @(negedge clock);
   endtask

   // receiver: modes of free flow, coin toss and stall bursts, plus two long
   // hold-offs that back the block up into req_ready
   initial begin
      int mode;
      int steps;
      int rx_cycles;
      int holdoffs;
      rsp_ready = 1'b0;
      rx_cycles = 0;
      holdoffs  = 0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         mode  = $urandom_range(0, 2);
         steps = 0;
         while (steps < 150) begin
            if ((holdoffs == 0 && rx_cycles > 3000) || (holdoffs == 1 && rx_cycles > 20000)) begin
               rsp_ready = 1'b0;
               repeat (400) @(negedge clock);
               rx_cycles = rx_cycles + 400;
               holdoffs  = holdoffs + 1;
            end
            case (mode)
               0: begin
                  rsp_ready = 1'b1;
                  @(negedge clock);
                  steps++;
               end
               1: begin
                  rsp_ready = 1'($urandom_range(0, 1));
                  @(negedge clock);
                  steps++;
               end
               default: begin
                  rsp_ready = 1'b0;
                  repeat (pick_gap() + 1) begin
                     @(negedge clock);
                     steps++;
                  end
                  rsp_ready = 1'b1;
                  @(negedge clock);
                  steps++;
               end
            endcase
            rx_cycles = rx_cycles + 1;
         end
      end
   end

   initial begin
      logic [15:0] directed_words [$];
      logic [15:0] level;
      logic [15:0] word;
      int          kind;
      int          burst;
      int          gap;
      int          n;
      directed_words = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                         16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE, 16'hAAAA, 16'h5555,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 16'h0F0F, 16'hF0F0, 16'h0000};
      cycle_count  = 0;
      words_sent   = 0;
      sd_acc       = 16'h0000;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_pdm_word = 16'h0000;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_words[i])
         send_word(directed_words[i], (i < 12) ? 0 : pick_gap());

      n = 0;
      while (n < RANDOM_WORDS) begin
         kind  = $urandom_range(0, 3);
         burst = $urandom_range(4, 40);
         level = 16'($urandom_range(0, 65535));
         repeat (burst) begin
            case (kind)
               0: word = 16'($urandom_range(0, 65535));
               1, 2: word = sigma_delta_word(level);
               default: begin
                  // near full scale, sometimes one bit flipped
                  word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                  if ($urandom_range(0, 3) == 0)
                     word[4'($urandom_range(0, 15))] ^= 1'b1;
               end
            endcase
            // every third window of 200 words runs without gaps
            gap = ((n / 200) % 3 == 0) ? 0 : pick_gap();
            send_word(word, gap);
            n++;
         end
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("pdm_cic_decimator_unit test passed");
      else
         $display("pdm_cic_decimator_unit test failed");
      $finish;
   end

endmodule

[pdm_cic_decimator_unit.f]
sv/pdmcic_pkg.sv
sv/pdmcic_integ_cell.sv
sv/pdmcic_comb_cell.sv
sv/pdm_cic_decimator_unit.sv
dv/pdm_cic_decimator_unit_checker.sv
dv/pdm_cic_decimator_unit_test.sv
